// ===== hw/rtl/dtcd_pkg.sv =====
package dtcd_pkg;

   typedef logic signed [23:0] year_type;
   typedef logic signed [27:0] month_count_type;
   typedef logic [3:0]         month_type;
   typedef logic [4:0]         mday_type;
   typedef logic [8:0]         yday_type;

   typedef struct packed {
      logic leap;
      logic special;
   } year_flags_type;

   localparam logic [17:0] DAYS_400 = 18'd146097;
   localparam logic [15:0] DAYS_100 = 16'd36524;
   localparam logic [10:0] DAYS_4Y  = 11'd1461;
   localparam logic [8:0]  DAYS_1Y  = 9'd365;

   // count is biased positive so the 400-year split is an unsigned divide
   localparam logic [15:0] Q400_BIAS = 16'd15000;
   localparam logic [33:0] U_BIAS    = 34'(64'd15000 * 64'd146097 - 64'd11323);
   localparam logic signed [31:0] SMALLEST_SAFE = -32'sd2147472324;

   // reciprocals, floored: quotient estimate is exact or one low
   localparam logic [30:0] RECIP_400 = 31'(64'd281474976710656 / 64'd146097);
   localparam logic [15:0] RECIP_4Y  = 16'(64'd67108864 / 64'd1461);

   localparam year_type  YEAR_BASE = 24'sd31;
   localparam month_type MONTH_DEC = 4'd11;
   localparam mday_type  LAST_MDAY = 5'd30;
   localparam yday_type  LAST_YDAY = 9'd365;

   function automatic logic [8:0] cum_days(input logic [3:0] idx);
      logic [8:0] v;
      case (idx)
         4'd0:    v = 9'd0;
         4'd1:    v = 9'd31;
         4'd2:    v = 9'd59;
         4'd3:    v = 9'd90;
         4'd4:    v = 9'd120;
         4'd5:    v = 9'd151;
         4'd6:    v = 9'd181;
         4'd7:    v = 9'd212;
         4'd8:    v = 9'd243;
         4'd9:    v = 9'd273;
         4'd10:   v = 9'd304;
         4'd11:   v = 9'd334;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hw/rtl/days_to_civil_date_core.sv =====
// Throughput: one request per cycle; all 11 stages advance together and
// hold as one while rsp_valid is high and rsp_ready is low.
// Most stages belong to the two reciprocal multiply / correct chains (400-year, 4-year).
// Reset (synchronous) clears the stage valid bits only; data regs keep junk.
module days_to_civil_date_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [31:0]             req_day_count,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output dtcd_pkg::year_type             rsp_epoch_year,
   output dtcd_pkg::month_type            rsp_month_index,
   output dtcd_pkg::mday_type             rsp_day_of_month,
   output dtcd_pkg::yday_type             rsp_day_of_year,
   output dtcd_pkg::month_count_type      rsp_month_offset,
   output logic                           rsp_invalid
);
   import dtcd_pkg::*;

   localparam int STAGES = 11;

   logic              advance;
   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] inv_ff;

   // stage 1
   logic [33:0] s1_u_in, s1_u_ff;
   logic        s1_inv_in;
   // stage 2
   logic [56:0] s2_p_in, s2_p_ff;
   logic [33:0] s2_u_ff;
   // stage 3
   logic [14:0] s3_q_in, s3_q_ff;
   logic [32:0] s3_prod_in, s3_prod_ff;
   logic [33:0] s3_u_ff;
   // stage 4
   logic [33:0] s4_diff;
   logic [18:0] s4_r;
   logic [17:0] s4_r400_in, s4_r400_ff;
   logic signed [15:0] s4_q400_in, s4_q400_ff;
   // stage 5
   logic [2:0]  s5_q100;
   logic [15:0] s5_n100_in, s5_n100_ff;
   year_type    s5_yacc_in, s5_yacc_ff;
   logic        s5_is3_in, s5_is3_ff, s5_is4_in, s5_is4_ff;
   // stage 6
   logic [31:0] s6_prod_in, s6_prod_ff;
   logic [15:0] s6_n100_ff;
   year_type    s6_yacc_ff;
   logic        s6_is3_ff, s6_is4_ff;
   // stage 7
   logic [4:0]  s7_q4_in, s7_q4_ff;
   logic [15:0] s7_prod_in, s7_prod_ff;
   logic [15:0] s7_n100_ff;
   year_type    s7_yacc_ff;
   logic        s7_is3_ff, s7_is4_ff;
   // stage 8
   logic [15:0] s8_diff;
   logic [11:0] s8_r;
   logic [10:0] s8_r4_in, s8_r4_ff;
   logic [4:0]  s8_q4_in, s8_q4_ff;
   year_type    s8_yacc_ff;
   logic        s8_is3_ff, s8_is4_ff;
   // stage 9
   logic [2:0]     s9_q1;
   logic [10:0]    s9_off;
   yday_type       s9_n1_in, s9_n1_ff;
   year_flags_type s9_flags_in, s9_flags_ff;
   year_type       s9_yoff_in, s9_yoff_ff;
   // stage 10
   year_type    s10_yoff_ff;
   month_type   s10_mon_ff;
   mday_type    s10_mday_ff;
   yday_type    s10_yday_ff;
   // stage 11
   year_type        out_yoff_in, out_yoff_ff;
   month_type       out_mon_in, out_mon_ff;
   mday_type        out_mday_in, out_mday_ff;
   yday_type        out_yday_in, out_yday_ff;
   month_count_type out_moff_in, out_moff_ff;

   assign advance   = !vld_ff[STAGES-1] || rsp_ready;
   assign req_ready = advance && !reset;

   always_comb begin
      // stage 1: range check and bias
      s1_inv_in = req_day_count < SMALLEST_SAFE;
      s1_u_in   = 34'(req_day_count) + U_BIAS;

      // stage 2: 400-year quotient estimate
      s2_p_in = 57'(s1_u_ff[33:8]) * 57'(RECIP_400);

      // stage 3
      s3_q_in    = s2_p_ff[54:40];
      s3_prod_in = 33'(s3_q_in) * 33'(DAYS_400);

      // stage 4: fix the one-low estimate
      s4_diff = s3_u_ff - 34'(s3_prod_ff);
      s4_r    = s4_diff[18:0];
      if (s4_r >= 19'(DAYS_400)) begin
         s4_r400_in = 18'(s4_r - 19'(DAYS_400));
         s4_q400_in = $signed(16'(s3_q_ff) + 16'd1 - Q400_BIAS);
      end else begin
         s4_r400_in = s4_r[17:0];
         s4_q400_in = $signed(16'(s3_q_ff) - Q400_BIAS);
      end

      // stage 5: century split, quotient 0..4
      if (s4_r400_ff >= 18'(DAYS_100) * 18'd4) begin
         s5_q100 = 3'd4;
      end else if (s4_r400_ff >= 18'(DAYS_100) * 18'd3) begin
         s5_q100 = 3'd3;
      end else if (s4_r400_ff >= 18'(DAYS_100) * 18'd2) begin
         s5_q100 = 3'd2;
      end else if (s4_r400_ff >= 18'(DAYS_100)) begin
         s5_q100 = 3'd1;
      end else begin
         s5_q100 = 3'd0;
      end
      s5_n100_in = 16'(s4_r400_ff - 18'(DAYS_100) * 18'(s5_q100));
      s5_yacc_in = 24'(s4_q400_ff) * 24'sd400 + $signed(24'(s5_q100) * 24'd100)
                 + YEAR_BASE;
      s5_is3_in  = s5_q100 == 3'd3;
      s5_is4_in  = s5_q100 == 3'd4;

      // stage 6: 4-year quotient estimate
      s6_prod_in = 32'(s5_n100_ff) * 32'(RECIP_4Y);

      // stage 7
      s7_q4_in   = s6_prod_ff[30:26];
      s7_prod_in = 16'(s7_q4_in) * 16'(DAYS_4Y);

      // stage 8
      s8_diff = s7_n100_ff - s7_prod_ff;
      s8_r    = s8_diff[11:0];
      if (s8_r >= 12'(DAYS_4Y)) begin
         s8_r4_in = 11'(s8_r - 12'(DAYS_4Y));
         s8_q4_in = s7_q4_ff + 5'd1;
      end else begin
         s8_r4_in = s8_r[10:0];
         s8_q4_in = s7_q4_ff;
      end

      // stage 9: year within 4-year cycle, quotient 0..4
      if (s8_r4_ff >= 11'(DAYS_1Y) * 11'd4) begin
         s9_q1 = 3'd4;
      end else if (s8_r4_ff >= 11'(DAYS_1Y) * 11'd3) begin
         s9_q1 = 3'd3;
      end else if (s8_r4_ff >= 11'(DAYS_1Y) * 11'd2) begin
         s9_q1 = 3'd2;
      end else if (s8_r4_ff >= 11'(DAYS_1Y)) begin
         s9_q1 = 3'd1;
      end else begin
         s9_q1 = 3'd0;
      end
      s9_off   = 11'(DAYS_1Y) * 11'(s9_q1);
      s9_n1_in = 9'(s8_r4_ff - s9_off);
      // last day of a leap cycle belongs to the year before
      s9_flags_in.special = (s9_q1 == 3'd4) || s8_is4_ff;
      s9_flags_in.leap    = (s9_q1 == 3'd3) && ((s8_q4_ff != 5'd24) || s8_is3_ff);
      s9_yoff_in = s8_yacc_ff + $signed(24'(s8_q4_ff) * 24'd4 + 24'(s9_q1))
                 - $signed(24'(s9_flags_in.special));

      // stage 11: month count and zeroing of out-of-range requests
      if (inv_ff[STAGES-2]) begin
         out_yoff_in = '0;
         out_mon_in  = '0;
         out_mday_in = '0;
         out_yday_in = '0;
         out_moff_in = '0;
      end else begin
         out_yoff_in = s10_yoff_ff;
         out_mon_in  = s10_mon_ff;
         out_mday_in = s10_mday_ff;
         out_yday_in = s10_yday_ff;
         out_moff_in = 28'(s10_yoff_ff) * 28'sd12 + $signed(28'(s10_mon_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STAGES-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         inv_ff      <= {inv_ff[STAGES-2:0], s1_inv_in};
         s1_u_ff     <= s1_u_in;
         s2_p_ff     <= s2_p_in;
         s2_u_ff     <= s1_u_ff;
         s3_q_ff     <= s3_q_in;
         s3_prod_ff  <= s3_prod_in;
         s3_u_ff     <= s2_u_ff;
         s4_r400_ff  <= s4_r400_in;
         s4_q400_ff  <= s4_q400_in;
         s5_n100_ff  <= s5_n100_in;
         s5_yacc_ff  <= s5_yacc_in;
         s5_is3_ff   <= s5_is3_in;
         s5_is4_ff   <= s5_is4_in;
         s6_prod_ff  <= s6_prod_in;
         s6_n100_ff  <= s5_n100_ff;
         s6_yacc_ff  <= s5_yacc_ff;
         s6_is3_ff   <= s5_is3_ff;
         s6_is4_ff   <= s5_is4_ff;
         s7_q4_ff    <= s7_q4_in;
         s7_prod_ff  <= s7_prod_in;
         s7_n100_ff  <= s6_n100_ff;
         s7_yacc_ff  <= s6_yacc_ff;
         s7_is3_ff   <= s6_is3_ff;
         s7_is4_ff   <= s6_is4_ff;
         s8_r4_ff    <= s8_r4_in;
         s8_q4_ff    <= s8_q4_in;
         s8_yacc_ff  <= s7_yacc_ff;
         s8_is3_ff   <= s7_is3_ff;
         s8_is4_ff   <= s7_is4_ff;
         s9_n1_ff    <= s9_n1_in;
         s9_flags_ff <= s9_flags_in;
         s9_yoff_ff  <= s9_yoff_in;
         s10_yoff_ff <= s9_yoff_ff;
         out_yoff_ff <= out_yoff_in;
         out_mon_ff  <= out_mon_in;
         out_mday_ff <= out_mday_in;
         out_yday_ff <= out_yday_in;
         out_moff_ff <= out_moff_in;
      end
   end

   dtcd_month u_month (
      .clock   (clock),
      .advance (advance),
      .day_num (s9_n1_ff),
      .flags   (s9_flags_ff),
      .mon_ff  (s10_mon_ff),
      .mday_ff (s10_mday_ff),
      .yday_ff (s10_yday_ff)
   );

   assign rsp_valid        = vld_ff[STAGES-1];
   assign rsp_invalid      = inv_ff[STAGES-1];
   assign rsp_epoch_year   = out_yoff_ff;
   assign rsp_month_index  = out_mon_ff;
   assign rsp_day_of_month = out_mday_ff;
   assign rsp_day_of_year  = out_yday_ff;
   assign rsp_month_offset = out_moff_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_invalid |-> rsp_epoch_year == '0 && rsp_month_index == '0
         && rsp_day_of_month == '0 && rsp_day_of_year == '0 && rsp_month_offset == '0)
      else $error("invalid request produced nonzero fields");

   a_month_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_invalid |->
         rsp_month_offset == 28'(rsp_epoch_year) * 28'sd12 + $signed(28'(rsp_month_index)))
      else $error("month count does not match year and month");

   a_field_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_invalid |-> rsp_month_index <= MONTH_DEC
         && rsp_day_of_month <= LAST_MDAY && rsp_day_of_year <= LAST_YDAY)
      else $error("calendar field out of range");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(vld_ff) && $stable(inv_ff))
      else $error("pipeline moved during output stall");

endmodule

// ===== hw/rtl/dtcd_month.sv =====
module dtcd_month (
   input  logic                     clock,
   input  logic                     advance,
   input  dtcd_pkg::yday_type       day_num,
   input  dtcd_pkg::year_flags_type flags,
   output dtcd_pkg::month_type      mon_ff,
   output dtcd_pkg::mday_type       mday_ff,
   output dtcd_pkg::yday_type       yday_ff
);
   import dtcd_pkg::*;

   logic [9:0] sum;
   logic [3:0] guess;
   logic [3:0] m_hi;
   logic [8:0] b_hi;
   logic [8:0] b_lo;
   month_type  mon_in;
   mday_type   mday_in;
   yday_type   yday_in;

   always_comb begin
      sum   = 10'(day_num) + 10'd50;
      guess = 4'(sum >> 5);
      if (guess == 4'd0) begin
         m_hi = 4'd1;
      end else if (guess > 4'd12) begin
         m_hi = 4'd12;
      end else begin
         m_hi = guess;
      end
      // days before the guessed month and before the month preceding it
      b_hi = cum_days(m_hi - 4'd1) + 9'(flags.leap && (m_hi > 4'd2));
      b_lo = cum_days(m_hi - 4'd2) + 9'(flags.leap && (m_hi > 4'd3));
      yday_in = day_num;
      if (flags.special) begin
         mon_in  = MONTH_DEC;
         mday_in = LAST_MDAY;
         yday_in = LAST_YDAY;
      end else if ((b_hi > day_num) && (m_hi > 4'd1)) begin
         mon_in  = m_hi - 4'd2;
         mday_in = 5'(day_num - b_lo);
      end else begin
         mon_in  = m_hi - 4'd1;
         mday_in = 5'(day_num - b_hi);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mon_ff  <= mon_in;
         mday_ff <= mday_in;
         yday_ff <= yday_in;
      end
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import dtcd_pkg::*;

   typedef struct packed {
      year_type        epoch_year;
      month_type       month_index;
      mday_type        day_of_month;
      yday_type        day_of_year;
      month_count_type month_offset;
      logic            invalid;
   } civil_date_type;

   localparam longint LOWEST_VALID_COUNT = -2147472324;
   localparam longint DAYS_1970_TO_2001  = 11323;
   localparam longint DAYS_IN_400Y       = 146097;
   localparam longint DAYS_IN_100Y       = 36524;
   localparam longint DAYS_IN_4Y         = 1461;
   localparam longint DAYS_IN_1Y         = 365;
   localparam longint YEARS_1970_TO_2001 = 31;

   int days_before_month [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic signed [31:0] req_day_count = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   year_type          rsp_epoch_year;
   month_type         rsp_month_index;
   mday_type          rsp_day_of_month;
   yday_type          rsp_day_of_year;
   month_count_type   rsp_month_offset;
   logic              rsp_invalid;

   civil_date_type pending_dates [$];
   int  error_count = 0;
   int  dates_checked = 0;
   int  invalid_seen = 0;
   int  cycle_end_seen = 0;
   int  input_stall_cycles = 0;
   int  rsp_hold_cycles = 0;
   bit  sender_pauses = 1'b1;
   bit  receiver_pauses = 1'b1;

   days_to_civil_date_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_day_count    (req_day_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_epoch_year   (rsp_epoch_year),
      .rsp_month_index  (rsp_month_index),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_day_of_year  (rsp_day_of_year),
      .rsp_month_offset (rsp_month_offset),
      .rsp_invalid      (rsp_invalid)
   );

   always #2 clock = ~clock;

   // floor division: remainder always in [0, b)
   function automatic void floor_split(input longint a, input longint b,
                                       output longint q, output longint r);
      q = a / b;
      r = a % b;
      if (r < 0) begin
         r = r + b;
         q = q - 1;
      end
   endfunction

   function automatic civil_date_type civil_from_days(input logic signed [31:0] day_count);
      civil_date_type d;
      longint n, q400, q100, q4, q1, yoff, mon, m, start;
      bit leap;
      d = '0;
      if (longint'(day_count) < LOWEST_VALID_COUNT) begin
         d.invalid = 1'b1;
         return d;
      end
      floor_split(longint'(day_count) - DAYS_1970_TO_2001, DAYS_IN_400Y, q400, n);
      floor_split(n, DAYS_IN_100Y, q100, n);
      floor_split(n, DAYS_IN_4Y, q4, n);
      floor_split(n, DAYS_IN_1Y, q1, n);
      yoff = q400 * 400 + q100 * 100 + q4 * 4 + q1 + YEARS_1970_TO_2001;
      if (q1 == 4 || q100 == 4) begin
         // day 366 of a leap year: Dec 31 of the year before
         yoff = yoff - 1;
         mon = 11;
         d.day_of_month = 5'd30;
         d.day_of_year = 9'd365;
      end else begin
         leap = (q1 == 3) && (q4 != 24 || q100 == 3);
         m = (n + 50) >>> 5;
         if (m < 1) m = 1;
         if (m > 12) m = 12;
         start = days_before_month[m - 1] + ((leap && m > 2) ? 1 : 0);
         if (start > n && m > 1) begin
            m = m - 1;
            start = days_before_month[m - 1] + ((leap && m > 2) ? 1 : 0);
         end
         mon = m - 1;
         d.day_of_month = 5'(n - start);
         d.day_of_year = 9'(n);
      end
      d.epoch_year = 24'(yoff);
      d.month_index = 4'(mon);
      d.month_offset = 28'(yoff * 12 + mon);
      return d;
   endfunction

   task automatic send_request(input logic signed [31:0] day_count);
      int gap;
      gap = sender_pauses ? $urandom_range(0, 5) : 0;
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_day_count <= day_count;
      do @(posedge clock); while (!req_ready);
      pending_dates.push_back(civil_from_days(day_count));
   endtask

   task automatic test_calendar_corners();
      logic signed [31:0] corners [$];
      corners = '{32'sd0, -32'sd1, 32'sd59, 32'sd364, 32'sd789, 32'sd790,
                  32'sd10956, 32'sd11016, 32'sd11322, 32'sd11323, 32'sd12783,
                  32'sd12784, -32'sd25509, -32'sd25508, 32'sd47540, 32'sd47541,
                  32'sd157419, 32'sh7fffffff, 32'sh80000000, 32'sh80000001,
                  -32'sd2147472325, -32'sd2147472324, -32'sd2147472323};
      foreach (corners[i])
         send_request(corners[i]);
   endtask

   task automatic test_random_dates(input int count);
      longint v;
      repeat (count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3:
               v = longint'($urandom_range(0, 1600000)) - 800000;
            4, 5:
               v = longint'(int'($urandom));
            6, 7: begin
               // land on or next to a 400/100/4/1-year cycle boundary
               v = (longint'($urandom_range(0, 29200)) - 14600) * DAYS_IN_400Y
                   + DAYS_1970_TO_2001
                   + longint'($urandom_range(0, 4)) * DAYS_IN_100Y
                   + longint'($urandom_range(0, 24)) * DAYS_IN_4Y
                   + longint'($urandom_range(0, 4)) * DAYS_IN_1Y
                   + longint'($urandom_range(0, 4)) - 2;
            end
            8:
               v = LOWEST_VALID_COUNT + longint'($urandom_range(0, 8)) - 4;
            default:
               v = 64'sd2147483647 - longint'($urandom_range(0, 400));
         endcase
         send_request(32'(v));
      end
   endtask

   task automatic test_back_to_back(input int count);
      sender_pauses = 1'b0;
      receiver_pauses = 1'b0;
      repeat (count)
         send_request(32'(longint'($urandom_range(0, 200000)) - 100000));
      sender_pauses = 1'b1;
      receiver_pauses = 1'b1;
   endtask

   // receiver freezes after its next result while requests keep coming
   task automatic test_output_backpressure();
      sender_pauses = 1'b0;
      rsp_hold_cycles = 120;
      repeat (60)
         send_request(32'($urandom));
      sender_pauses = 1'b1;
   endtask

   initial begin : receiver
      int stall;
      wait (reset == 1'b0);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = receiver_pauses ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic void check_field(input string field, input longint want,
                                       input longint got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && !req_ready)
         input_stall_cycles++;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dates.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, got year %0d month %0d",
                     $time, rsp_epoch_year, rsp_month_index);
         end else begin
            civil_date_type want;
            want = pending_dates.pop_front();
            check_field("epoch_year", want.epoch_year, rsp_epoch_year);
            check_field("month_index", want.month_index, rsp_month_index);
            check_field("day_of_month", want.day_of_month, rsp_day_of_month);
            check_field("day_of_year", want.day_of_year, rsp_day_of_year);
            check_field("month_offset", want.month_offset, rsp_month_offset);
            check_field("invalid", want.invalid, rsp_invalid);
            dates_checked++;
            if (want.invalid) invalid_seen++;
            if (!want.invalid && want.day_of_year == 9'd365) cycle_end_seen++;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_calendar_corners();
      test_random_dates(1520);
      test_back_to_back(150);
      test_output_backpressure();
      req_valid <= 1'b0;
      while (pending_dates.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      $display("Converted %0d day counts: %0d below the safe range, %0d on Dec 31 of leap years",
               dates_checked, invalid_seen, cycle_end_seen);
      $display("Input held off for %0d cycles by output backpressure", input_stall_cycles);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout with %0d requests outstanding", pending_dates.size());
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/dtcd_pkg.sv
hw/rtl/dtcd_month.sv
hw/rtl/days_to_civil_date_core.sv
dv/testbench.sv
